### hdl/ps2mct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared types and constants for the PS/2 mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  // cursor counter width (valid range 10..31)
  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = 16;   // screen size register width
  localparam int OUT_BITS   = 16;   // cursor output field width
  localparam int BTN_BITS   = 3;
  localparam int BYTE_BITS  = 8;

  // working width for position plus delta, wide enough for size - 1 too
  localparam int SUM_BITS =
    ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;

  // flag byte bit positions
  localparam int BIT_MARK  = 3;
  localparam int BIT_XSIGN = 4;
  localparam int BIT_YSIGN = 5;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

  // packet queue sizing
  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = 1;
  localparam int QCNT_BITS = 2;

  // stream widths
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 40;   // 35 bits of fields, padded to bytes

  typedef enum logic [1:0] {
    POS_FLAG   = 2'd0,
    POS_XDELTA = 2'd1,
    POS_YDELTA = 2'd2
  } pkt_pos_t;

  // decoded packet handed from front to back
  typedef struct packed {
    logic [BTN_BITS-1:0]  buttons;
    logic                 x_sign;
    logic                 y_sign;
    logic [BYTE_BITS-1:0] x_lo;
    logic [BYTE_BITS-1:0] y_lo;
  } pkt_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage
`default_nettype wire

### hdl/ps2mct_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_front
// Gathers mouse bytes into three-byte packets and queues marked packets.
// ----------------------------------------------------------------------------
module ps2mct_front
  import ps2mct_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [IN_TDATA_BITS-1:0] s_tdata,   // [7:0] rx_byte
  input  wire q_status_t                q_stat,
  output logic                          push,
  output pkt_t                          push_pkt
);

  pkt_pos_t             pos;
  pkt_pos_t             pos_next;
  logic [BYTE_BITS-1:0] flag_byte;
  logic [BYTE_BITS-1:0] x_delta_byte;
  logic [BYTE_BITS-1:0] rx_byte;
  logic                 accept;
  logic                 last_byte;

  assign rx_byte = s_tdata[BYTE_BITS-1:0];
  assign accept  = s_tvalid && s_tready;

  // the unused position code counts as the third byte
  assign last_byte = (pos != POS_FLAG) && (pos != POS_XDELTA);

  always_comb begin
    pos_next = pos;
    if (accept) begin
      unique case (pos)
        POS_FLAG:   pos_next = POS_XDELTA;
        POS_XDELTA: pos_next = POS_YDELTA;
        default:    pos_next = POS_FLAG;
      endcase
    end
  end

  always_comb begin
    // stall only the closing byte when the queue is full
    s_tready          = !last_byte || !q_stat.full;
    push              = accept && last_byte && flag_byte[BIT_MARK];
    push_pkt.buttons  = flag_byte[BTN_BITS-1:0];
    push_pkt.x_sign   = flag_byte[BIT_XSIGN];
    push_pkt.y_sign   = flag_byte[BIT_YSIGN];
    push_pkt.x_lo     = x_delta_byte;
    push_pkt.y_lo     = rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_FLAG;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte    <= '0;
      x_delta_byte <= '0;
    end else if (accept) begin
      if (pos == POS_FLAG) begin
        flag_byte <= rx_byte;
      end
      if (pos == POS_XDELTA) begin
        x_delta_byte <= rx_byte;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_push_on_last: assert property (@(posedge clk) disable iff (rst)
    push |-> (accept && last_byte && !q_stat.full))
    else $error("packet pushed outside a closing beat");

  a_flag_then_x: assert property (@(posedge clk) disable iff (rst)
    (accept && pos == POS_FLAG) |=> (pos == POS_XDELTA && flag_byte == $past(rx_byte)))
    else $error("flag beat not captured");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (pos == POS_FLAG))
    else $error("packet did not close after third beat");
`endif

endmodule
`default_nettype wire

### hdl/ps2mct_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_queue
// Two-entry packet queue between the byte front and the cursor back.
// ----------------------------------------------------------------------------
module ps2mct_queue
  import ps2mct_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire pkt_t push_pkt,
  input  wire logic pop,
  output pkt_t      pop_pkt,
  output q_status_t q_stat
);

  pkt_t                 slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_pop;

  assign q_stat.full     = (count == QCNT_BITS'(QDEPTH));
  assign q_stat.nonempty = (count != '0);
  assign do_pop          = pop && q_stat.nonempty;
  assign pop_pkt         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/ps2mct_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_back
// Applies queued packets to the cursor, clamps each axis, drives results.
// ----------------------------------------------------------------------------
module ps2mct_back
  import ps2mct_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [SIZE_BITS-1:0]      cfg_data,
  input  wire q_status_t                 q_stat,
  input  wire pkt_t                      pop_pkt,
  output logic                           pop,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0]      m_tdata
);

  localparam logic signed [SUM_BITS-1:0] COORD_MAX_S =
    SUM_BITS'((64'd1 << COORD_BITS) - 64'd1);

  logic [SIZE_BITS-1:0]         screen_width;
  logic [SIZE_BITS-1:0]         screen_height;
  logic [COORD_BITS-1:0]        pos_x;
  logic [COORD_BITS-1:0]        pos_y;
  logic [BTN_BITS-1:0]          held_buttons;
  logic                         out_valid;
  logic signed [BYTE_BITS:0]    dx;
  logic signed [BYTE_BITS:0]    dy;
  logic signed [SUM_BITS-1:0]   sum_x;
  logic signed [SUM_BITS-1:0]   sum_y;
  logic [COORD_BITS-1:0]        pos_x_next;
  logic [COORD_BITS-1:0]        pos_y_next;

  function automatic logic [COORD_BITS-1:0] clamp_axis(
    input logic signed [SUM_BITS-1:0] v,
    input logic [SIZE_BITS-1:0]       size
  );
    logic signed [SUM_BITS-1:0] lim;
    logic signed [SUM_BITS-1:0] size_m1;
    logic signed [SUM_BITS-1:0] r;
    size_m1 = signed'(SUM_BITS'(size)) - SUM_BITS'(1);
    lim     = COORD_MAX_S;
    if (size != '0 && size_m1 < COORD_MAX_S) begin
      lim = size_m1;
    end
    r = v;
    if (v < 0) begin
      r = '0;
    end else if (v > lim) begin
      r = lim;
    end
    return r[COORD_BITS-1:0];
  endfunction

  assign cfg_ready = 1'b1;

  // take a packet when the output register is free or draining this cycle
  assign pop = q_stat.nonempty && (!out_valid || m_tready);

  assign dx    = signed'({pop_pkt.x_sign, pop_pkt.x_lo});
  assign dy    = signed'({pop_pkt.y_sign, pop_pkt.y_lo});
  assign sum_x = signed'(SUM_BITS'(pos_x)) + SUM_BITS'(dx);
  assign sum_y = signed'(SUM_BITS'(pos_y)) - SUM_BITS'(dy);
  assign pos_x_next = clamp_axis(sum_x, screen_width);
  assign pos_y_next = clamp_axis(sum_y, screen_height);

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA_BITS - 2*OUT_BITS - BTN_BITS){1'b0}},
                     held_buttons, OUT_BITS'(pos_y), OUT_BITS'(pos_x)};

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= '0;
      screen_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default:           screen_width  <= screen_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= '0;
      pos_y        <= '0;
      held_buttons <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        pos_x        <= pos_x_next;
        pos_y        <= pos_y_next;
        held_buttons <= pop_pkt.buttons;
        out_valid    <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped packet produced no beat");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !pop |=> ($stable(pos_x) && $stable(pos_y) && $stable(held_buttons)))
    else $error("cursor moved without a packet");

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    pop |-> (q_stat.nonempty && (!out_valid || m_tready)))
    else $error("packet taken while output stalled");
`endif

endmodule
`default_nettype wire

### hdl/ps2_mouse_packet_cursor_tracker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_top
// PS/2 three-byte packet decoder that tracks a clamped cursor position.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  s_*      | in  | s_tvalid / s_tready  | s_tdata[7:0] rx_byte
//  m_*      | out | m_tvalid / m_tready  | m_tdata: x[15:0] y[31:16] buttons[34:32]
//  cfg_*    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data[15:0]
//
//  Takes one mouse byte per cycle while s_tready is high; a marked packet's
//  closing byte goes into the two-entry packet queue, then into the output
//  register that drives the result beat. These two set the rate: a stalled
//  m_tready backs up the queue, then holds only the next packet's third byte.
//  rst is synchronous: cursor, buttons, sizes and byte position clear to 0.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_top
  import ps2mct_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,   // [7:0] rx_byte
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0]      m_tdata,   // [15:0] cursor_x,
                                                    // [31:16] cursor_y,
                                                    // [34:32] button_bits
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [SIZE_BITS-1:0]      cfg_data
);

  q_status_t q_stat;
  logic      push;
  pkt_t      push_pkt;
  logic      pop;
  pkt_t      pop_pkt;

  ps2mct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_stat   (q_stat),
    .push     (push),
    .push_pkt (push_pkt)
  );

  ps2mct_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (pop),
    .pop_pkt  (pop_pkt),
    .q_stat   (q_stat)
  );

  ps2mct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .pop_pkt   (pop_pkt),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire
